@@ rtl/pwa_pkg.sv @@
// shared constants for the per-user window average block
// no dependencies; used by pwa_div and per_user_window_average_unit
`default_nettype none

package pwa_pkg;

  // window and user geometry
  localparam int WINDOW_LEN = 30;
  localparam int USER_COUNT = 16;

  // field widths
  localparam int USER_W   = 4;
  localparam int SAMPLE_W = 32;
  localparam int PER_W    = 8;
  localparam int MEAN_W   = 32;

  // derived widths
  localparam int CNT_W     = $clog2(WINDOW_LEN + 1);
  localparam int SLOT_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int DEPTH     = USER_COUNT * WINDOW_LEN;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W     = SAMPLE_W + CNT_W;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // action codes
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

endpackage

`default_nettype wire

@@ rtl/pwa_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module pwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/pwa_div.sv @@
// restoring serial divider, one quotient bit per cycle
// depends on pwa_pkg
`default_nettype none

module pwa_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [pwa_pkg::SUM_W-1:0]    dividend,
  input  wire logic [pwa_pkg::CNT_W-1:0]    divisor,
  output logic                              done,
  output logic      [pwa_pkg::SUM_W-1:0]    quotient
);

  logic                           busy_r;
  logic                           done_r;
  logic [pwa_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [pwa_pkg::CNT_W-1:0]      rem_r;
  logic [pwa_pkg::CNT_W-1:0]      div_r;
  logic [pwa_pkg::SUM_W-1:0]      quo_r;

  logic [pwa_pkg::CNT_W:0]        trial;
  logic                           fits;
  logic [pwa_pkg::CNT_W:0]        diff;

  // shift next dividend bit into the partial remainder
  always_comb begin
    trial = {rem_r, quo_r[pwa_pkg::SUM_W-1]};
    fits  = (trial >= {1'b0, div_r});
    diff  = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= pwa_pkg::DIV_CNT_W'(pwa_pkg::SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == pwa_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low bits suffice
      rem_r <= fits ? diff[pwa_pkg::CNT_W-1:0] : trial[pwa_pkg::CNT_W-1:0];
      quo_r <= {quo_r[pwa_pkg::SUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ rtl/per_user_window_average_unit.sv @@
// top level: per-user sliding window of samples with mean on query
// depends on pwa_pkg, pwa_ram (sample store) and pwa_div (serial divider)
//
//   channel | direction | fields                                   | handshake
//   in_     | input     | action, user, sample_value, periods      | in_valid / in_stall
//   out_    | output    | mean_value, samples_used                 | out_valid / out_stall
//
// an add item writes its ring slot and updates the fill count and write pointer on accept
// a query with n > 0 samples reads and sums them through the one ram read port, runs
// the divider (start, 37-bit quotient, done) and then loads the output register;
// n = 0 skips the reads and the divider and loads a zero mean into the output register
// reset clears the fill counts and write pointers; the store needs no clear
// in_stall is high while a query is in flight; a waiting result holds only the final load
`default_nettype none

module per_user_window_average_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input item channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_action,
  input  wire logic [pwa_pkg::USER_W-1:0]    in_user,
  input  wire logic [pwa_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  wire logic [pwa_pkg::PER_W-1:0]     in_periods,
  // result item channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [pwa_pkg::MEAN_W-1:0]    out_mean_value,
  output logic      [pwa_pkg::CNT_W-1:0]     out_samples_used
);

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SUM    = 5'b00010,
    S_DSTART = 5'b00100,
    S_DWAIT  = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // per-user ring bookkeeping
  logic [pwa_pkg::CNT_W-1:0]  fill_r  [pwa_pkg::USER_COUNT];
  logic [pwa_pkg::SLOT_W-1:0] wslot_r [pwa_pkg::USER_COUNT];

  // query working registers
  logic [pwa_pkg::ADDR_W-1:0] base_r;
  logic [pwa_pkg::SLOT_W-1:0] slot_r;
  logic [pwa_pkg::CNT_W-1:0]  n_r;
  logic [pwa_pkg::CNT_W-1:0]  issue_r;
  logic                       rd_vld_r;
  logic [pwa_pkg::SUM_W-1:0]  sum_r;
  logic [pwa_pkg::MEAN_W-1:0] mean_r;

  // output register
  logic                       out_valid_r;
  logic [pwa_pkg::MEAN_W-1:0] out_mean_r;
  logic [pwa_pkg::CNT_W-1:0]  out_used_r;

  // accept-time decode
  logic                       accept;
  logic                       user_ok;
  logic [pwa_pkg::CNT_W-1:0]  cur_fill;
  logic [pwa_pkg::SLOT_W-1:0] cur_wslot;
  logic [pwa_pkg::SLOT_W-1:0] next_wslot;
  logic [pwa_pkg::SLOT_W-1:0] newest_slot;
  logic [pwa_pkg::ADDR_W-1:0] in_base;
  logic [pwa_pkg::PER_W-1:0]  fill_ext;
  logic [pwa_pkg::CNT_W-1:0]  n_sel;

  // ram and divider hookup
  logic                         ram_we;
  logic [pwa_pkg::ADDR_W-1:0]   ram_waddr;
  logic [pwa_pkg::ADDR_W-1:0]   ram_raddr;
  logic [pwa_pkg::SAMPLE_W-1:0] ram_rdata;
  logic                         issue;
  logic                         div_start;
  logic                         div_done;
  logic [pwa_pkg::SUM_W-1:0]    div_quo;
  logic                         out_free;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    user_ok     = ({1'b0, in_user} < (pwa_pkg::USER_W + 1)'(pwa_pkg::USER_COUNT));
    cur_fill    = fill_r[in_user];
    cur_wslot   = wslot_r[in_user];
    // ring pointer wraps at the window length
    next_wslot  = (cur_wslot == pwa_pkg::SLOT_W'(pwa_pkg::WINDOW_LEN - 1)) ?
                  '0 : cur_wslot + 1'b1;
    newest_slot = (cur_wslot == '0) ?
                  pwa_pkg::SLOT_W'(pwa_pkg::WINDOW_LEN - 1) : cur_wslot - 1'b1;
    in_base     = pwa_pkg::ADDR_W'(in_user) * pwa_pkg::ADDR_W'(pwa_pkg::WINDOW_LEN);
    fill_ext    = pwa_pkg::PER_W'(cur_fill);
    // take min(periods, stored count); bad user selects nothing
    if (!user_ok) begin
      n_sel = '0;
    end else if (in_periods < fill_ext) begin
      n_sel = in_periods[pwa_pkg::CNT_W-1:0];
    end else begin
      n_sel = cur_fill;
    end
  end

  // add writes land in the accept cycle
  assign ram_we    = accept && (in_action == pwa_pkg::ACT_ADD) && user_ok;
  assign ram_waddr = in_base + pwa_pkg::ADDR_W'(cur_wslot);
  assign ram_raddr = base_r + pwa_pkg::ADDR_W'(slot_r);
  assign issue     = (state_r == S_SUM) && (issue_r != n_r);
  assign div_start = (state_r == S_DSTART);

  pwa_ram #(
    .WIDTH (pwa_pkg::SAMPLE_W),
    .DEPTH (pwa_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_sample_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pwa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_action == pwa_pkg::ACT_QUERY)) begin
          state_nxt = (n_sel == '0) ? S_OUT : S_SUM;
        end
      end
      S_SUM: begin
        // all reads issued and the last read data folded in
        if ((issue_r == n_r) && !rd_vld_r) begin
          state_nxt = S_DSTART;
        end
      end
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      for (int i = 0; i < pwa_pkg::USER_COUNT; i++) begin
        fill_r[i]  <= '0;
        wslot_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (ram_we) begin
        wslot_r[in_user] <= next_wslot;
        if (cur_fill != pwa_pkg::CNT_W'(pwa_pkg::WINDOW_LEN)) begin
          fill_r[in_user] <= cur_fill + 1'b1;
        end
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && (in_action == pwa_pkg::ACT_QUERY)) begin
      base_r  <= in_base;
      slot_r  <= newest_slot;
      n_r     <= n_sel;
      issue_r <= '0;
      sum_r   <= '0;
      mean_r  <= '0;
    end else begin
      if (issue) begin
        issue_r <= issue_r + 1'b1;
        // walk backward from the newest sample
        slot_r  <= (slot_r == '0) ?
                   pwa_pkg::SLOT_W'(pwa_pkg::WINDOW_LEN - 1) : slot_r - 1'b1;
      end
      if (rd_vld_r) begin
        sum_r <= sum_r + pwa_pkg::SUM_W'(ram_rdata);
      end
      if (div_done) begin
        mean_r <= div_quo[pwa_pkg::MEAN_W-1:0];
      end
    end
    if ((state_r == S_OUT) && out_free) begin
      out_mean_r <= mean_r;
      out_used_r <= n_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mean_value   = out_mean_r;
  assign out_samples_used = out_used_r;

endmodule

`default_nettype wire

@@ tb/per_user_window_average_unit_tb.sv @@
// testbench for per_user_window_average_unit: directed and random add/query items
// with a scoreboard class that mirrors the per-user sample windows
// depends on rtl/pwa_pkg.sv and rtl/per_user_window_average_unit.sv
`timescale 1ns / 100ps

module per_user_window_average_unit_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 120;

  // one expected result item
  typedef struct packed {
    logic [pwa_pkg::MEAN_W-1:0] mean;
    logic [pwa_pkg::CNT_W-1:0]  used;
  } window_mean_t;

  // mirrors the sample windows and holds the means still owed by the block
  class window_mean_scoreboard;
    logic [pwa_pkg::SAMPLE_W-1:0] samples [pwa_pkg::USER_COUNT][pwa_pkg::WINDOW_LEN];
    int unsigned                  fill [pwa_pkg::USER_COUNT];
    int unsigned                  wslot [pwa_pkg::USER_COUNT];
    window_mean_t                 owed_means [$];
    int                           errors;

    function new();
      for (int u = 0; u < pwa_pkg::USER_COUNT; u++) begin
        fill[u] = 0;
        wslot[u] = 0;
        for (int s = 0; s < pwa_pkg::WINDOW_LEN; s++) samples[u][s] = '0;
      end
      errors = 0;
    endfunction

    // update the windows on an add, work out the mean on a query
    function void note_item(logic act, logic [pwa_pkg::USER_W-1:0] usr,
                            logic [pwa_pkg::SAMPLE_W-1:0] smp,
                            logic [pwa_pkg::PER_W-1:0] per);
      int unsigned               n;
      int unsigned               idx;
      logic [pwa_pkg::SUM_W-1:0] sum;
      window_mean_t              res;
      if (act == pwa_pkg::ACT_ADD) begin
        if (usr < pwa_pkg::USER_COUNT) begin
          samples[usr][wslot[usr]] = smp;
          wslot[usr] = (wslot[usr] + 1) % pwa_pkg::WINDOW_LEN;
          if (fill[usr] < pwa_pkg::WINDOW_LEN) fill[usr]++;
        end
      end else begin
        n = 0;
        sum = '0;
        if (usr < pwa_pkg::USER_COUNT) begin
          n = (per < fill[usr]) ? per : fill[usr];
          for (int k = 0; k < n; k++) begin
            idx = (wslot[usr] + pwa_pkg::WINDOW_LEN - 1 - k) % pwa_pkg::WINDOW_LEN;
            sum += samples[usr][idx];
          end
        end
        res.mean = (n != 0) ? pwa_pkg::MEAN_W'(sum / n) : '0;
        res.used = pwa_pkg::CNT_W'(n);
        owed_means = {owed_means, res};
      end
    endfunction

    function void check_result(logic [pwa_pkg::MEAN_W-1:0] mean,
                               logic [pwa_pkg::CNT_W-1:0] used);
      window_mean_t want;
      if (owed_means.size() == 0) begin
        $error("unexpected result: mean_value %0h, samples_used %0d", mean, used);
        errors++;
      end else begin
        want = owed_means.pop_front();
        if (mean !== want.mean) begin
          $error("mean_value: expected %0h, actual %0h", want.mean, mean);
          errors++;
        end
        if (used !== want.used) begin
          $error("samples_used: expected %0d, actual %0d", want.used, used);
          errors++;
        end
      end
    endfunction

    function int pending();
      return owed_means.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_action;
  logic [pwa_pkg::USER_W-1:0]   in_user;
  logic [pwa_pkg::SAMPLE_W-1:0] in_sample_value;
  logic [pwa_pkg::PER_W-1:0]    in_periods;
  logic                         out_valid;
  logic                         out_stall;
  logic [pwa_pkg::MEAN_W-1:0]   out_mean_value;
  logic [pwa_pkg::CNT_W-1:0]    out_samples_used;

  window_mean_scoreboard sb;

  // idle percentages of the current phase, and the long receiver hold-off request
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_go;
  int unsigned cycle_count;

  per_user_window_average_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_user          (in_user),
    .in_sample_value  (in_sample_value),
    .in_periods       (in_periods),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mean_value   (out_mean_value),
    .out_samples_used (out_samples_used)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // watchdog on a cycle count
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("per_user_window_average_unit_tb: FAIL");
      $finish;
    end
  end

  // every accepted input item goes to the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_item(in_action, in_user, in_sample_value, in_periods);
  end

  // every accepted result item is checked against the oldest owed mean
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_mean_value, out_samples_used);
  end

  // receiver: random stall per phase, plus one long hold-off when asked
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        // block fills up behind this and must stall its input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // offer one item from a falling edge, wait for its accept, return at a falling edge
  task automatic send_item(input logic act, input logic [pwa_pkg::USER_W-1:0] usr,
                           input logic [pwa_pkg::SAMPLE_W-1:0] smp,
                           input logic [pwa_pkg::PER_W-1:0] per);
    // random sender gaps before the item
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_user         <= usr;
    in_sample_value <= smp;
    in_periods      <= per;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // random item: mostly well-formed adds and queries, biased so windows fill and wrap
  task automatic send_random_item();
    logic                         act;
    logic [pwa_pkg::USER_W-1:0]   usr;
    logic [pwa_pkg::SAMPLE_W-1:0] smp;
    logic [pwa_pkg::PER_W-1:0]    per;
    int unsigned                  pick;
    act = ($urandom_range(99) < 55) ? pwa_pkg::ACT_ADD : pwa_pkg::ACT_QUERY;
    // a few busy users get most of the traffic so their windows wrap often
    usr = ($urandom_range(99) < 60) ? pwa_pkg::USER_W'($urandom_range(3)) :
                                      pwa_pkg::USER_W'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 10) smp = '1;
    else if (pick < 20) smp = '0;
    else smp = $urandom;
    pick = $urandom_range(99);
    if (pick < 15) per = pwa_pkg::PER_W'($urandom_range(255));
    else if (pick < 25) per = '0;
    else if (pick < 35) per = pwa_pkg::PER_W'(pwa_pkg::WINDOW_LEN);
    else per = pwa_pkg::PER_W'($urandom_range(31, 1));
    send_item(act, usr, smp, per);
  endtask

  // hold the sender until every owed result item has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input int unsigned n_items);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n_items) send_random_item();
    wait_results_drained();
  endtask

  initial begin
    sb = new();
    cycle_count     = 0;
    hold_go         = 1'b0;
    send_idle_pct   = 29;
    recv_idle_pct   = 57;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = pwa_pkg::ACT_ADD;
    in_user         = '0;
    in_sample_value = '0;
    in_periods      = '0;
    out_stall       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty history, zero period, extremes of the sample and period
    send_item(pwa_pkg::ACT_QUERY, 4'd0, 32'hFFFF_FFFF, 8'd255);
    send_item(pwa_pkg::ACT_QUERY, 4'd0, 32'h0000_0000, 8'd0);
    send_item(pwa_pkg::ACT_ADD,   4'd0, 32'hFFFF_FFFF, 8'd0);
    send_item(pwa_pkg::ACT_ADD,   4'd0, 32'hFFFF_FFFF, 8'd255);
    send_item(pwa_pkg::ACT_ADD,   4'd0, 32'h0000_0000, 8'd0);
    send_item(pwa_pkg::ACT_QUERY, 4'd0, 32'h0000_0000, 8'd0);
    send_item(pwa_pkg::ACT_QUERY, 4'd0, 32'hFFFF_FFFF, 8'd1);
    send_item(pwa_pkg::ACT_QUERY, 4'd0, 32'h0000_0000, 8'd2);
    send_item(pwa_pkg::ACT_QUERY, 4'd0, 32'h0000_0000, 8'd3);
    // period beyond the stored count
    send_item(pwa_pkg::ACT_QUERY, 4'd0, 32'h0000_0000, 8'd255);
    send_item(pwa_pkg::ACT_QUERY, 4'd0, 32'h0000_0000, 8'd31);
    send_item(pwa_pkg::ACT_ADD,   4'd15, 32'h1234_5678, 8'hAA);
    send_item(pwa_pkg::ACT_ADD,   4'd15, 32'h5555_AAAA, 8'h55);
    send_item(pwa_pkg::ACT_QUERY, 4'd15, 32'hAAAA_5555, 8'd128);
    send_item(pwa_pkg::ACT_QUERY, 4'd15, 32'h0000_0001, 8'd1);
    // user that never saw an add
    send_item(pwa_pkg::ACT_QUERY, 4'd7, 32'h8000_0000, 8'd30);
    send_item(pwa_pkg::ACT_ADD,   4'd8, 32'h0000_0001, 8'd0);
    send_item(pwa_pkg::ACT_QUERY, 4'd8, 32'h0000_0000, 8'd30);
    send_item(pwa_pkg::ACT_QUERY, 4'd8, 32'h0000_0000, 8'd0);
    wait_results_drained();

    // receiver idles more, then sender idles more, then back to back
    run_phase(29, 57, 600);
    run_phase(57, 29, 600);
    // long receiver hold-off while the sender keeps offering items
    hold_go = 1'b1;
    run_phase(0, 0, 600);

    // let anything still in flight show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("per_user_window_average_unit_tb: PASS");
    end else begin
      $display("per_user_window_average_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ per_user_window_average_unit.f @@
rtl/pwa_pkg.sv
rtl/pwa_ram.sv
rtl/pwa_div.sv
rtl/per_user_window_average_unit.sv
tb/per_user_window_average_unit_tb.sv
